@@ sv/brq_pkg.sv @@
// Package for the bounded request queue: widths, codes, state type and defaults.
// Used by every module of the block; depends on nothing else.
package brq_pkg;

	localparam int ID_W        = 32;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 3;
	localparam int POLICY_W    = 2;
	localparam int CAP_W       = 5;
	localparam int LFSR_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int ITER_W      = 3;
	localparam int QUEUE_DEPTH = 16;
	localparam int CAP_LIMIT   = 16;

	localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_ONE  = 16'h0001;

	// Commands carried by an input transfer.
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_DONE = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	// Status codes of a result transfer.
	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED = 3'd0,
		ST_REJECTED = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_EVICTED  = 3'd3,
		ST_POPPED   = 3'd4,
		ST_EMPTY    = 3'd5,
		ST_BUDGET   = 3'd6
	} status_t;

	// Overflow policies.
	typedef enum logic [POLICY_W-1:0] {
		POL_BLOCK     = 2'd0,
		POL_DROP_TAIL = 2'd1,
		POL_DROP_HEAD = 2'd2,
		POL_DROP_RAND = 2'd3
	} policy_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY   = 2'd0,
		CFG_CAPACITY = 2'd1,
		CFG_SEED     = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_idx_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_POP,
		S_HEAD,
		S_PUSH,
		S_RND,
		S_MOD,
		S_REMIT,
		S_SH_RD,
		S_SH_WR
	} state_t;

	// One step of the Galois LFSR.
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_MASK;
		end
		return s;
	endfunction

endpackage

@@ sv/bounded_request_queue_drop_policy_top.sv @@
// Bounded request queue with overflow drop policy: sequencer, budget and LFSR.
// Depends on brq_pkg, brq_mem and brq_rem.
//
// Usage:
// The input channel (in_valid, in_stall, command, request_id) takes one command
// per transfer. The output channel (out_valid, out_stall, status, item_id,
// last_result) returns one to five results per command; last_result marks the
// final one. A command with code 3 returns nothing.
// One command is worked on at a time; in_stall stays high until the sequencer
// has placed the final result in the output register, so the next command can
// be taken while that result still waits on a stalled receiver.
// Accepted pushes and pops of stored entries go through dispatch and then the
// push or pop state; worker-done, an empty pop and a rejected or dropped push
// give their result from dispatch. Drop head adds an evict state. Drop random
// runs the bit-serial remainder unit per eviction and moves each entry above
// the pick down with a read and a write through the single read and write port
// of the entry store. While the output register holds a result and out_stall
// is high, the sequencer waits with its next result. Reset empties the queue,
// loads the budget with the capacity (16) and the LFSR with 1. The user writes
// the configuration port only while the block is idle, which is not enforced.
module bounded_request_queue_drop_policy_top #(
	parameter int QUEUE_DEPTH = brq_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [brq_pkg::CMD_W-1:0]      command,
	input  logic [brq_pkg::ID_W-1:0]       request_id,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [brq_pkg::STATUS_W-1:0]   status,
	output logic [brq_pkg::ID_W-1:0]       item_id,
	output logic                         last_result,
	input  logic                         cfg_write,
	input  logic [brq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import brq_pkg::*;

	localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int CAP_MAX = (QUEUE_DEPTH < CAP_LIMIT) ? QUEUE_DEPTH : CAP_LIMIT;

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [ID_W-1:0]   id_q;
	policy_t           policy_q;
	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     head_q, head_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CAP_W-1:0]  budget_q, budget_d;
	logic [LFSR_W-1:0] lfsr_q, lfsr_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic [CW-1:0]     j_q, j_d;
	logic [CAP_W-1:0]  eff_cap;
	logic              full;
	logic              can_emit;

	logic              emit;
	status_t           e_status;
	logic [ID_W-1:0]   e_id;
	logic              e_last;

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [ID_W-1:0]   mem_wdata, mem_rdata;

	logic              rem_start, rem_done;
	logic [CW-1:0]     rem_val;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_last_q;

	// Physical address of a logical queue offset in the circular store.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(off);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	brq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	brq_rem #(.CW(CW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (lfsr_d),
		.divisor  (count_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// Effective capacity and the full test.
	assign eff_cap  = (cap_q > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : cap_q;
	assign full     = int'(count_q) >= int'(budget_q);
	assign can_emit = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (cmd_q)
					CMD_PUSH: begin
						if (budget_q == '0 && policy_q != POL_BLOCK) begin
							if (can_emit) state_d = S_IDLE;
						end else if (full) begin
							if (policy_q == POL_DROP_HEAD) begin
								state_d = S_HEAD;
							end else if (policy_q == POL_DROP_RAND) begin
								state_d = S_RND;
							end else if (can_emit) begin
								state_d = S_IDLE;
							end
						end else begin
							state_d = S_PUSH;
						end
					end
					CMD_POP: begin
						if (count_q == '0) begin
							if (can_emit) state_d = S_IDLE;
						end else begin
							state_d = S_POP;
						end
					end
					CMD_DONE: begin
						if (can_emit) state_d = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_POP:   if (can_emit) state_d = S_IDLE;
			S_HEAD:  if (can_emit) state_d = S_PUSH;
			S_PUSH:  if (can_emit) state_d = S_IDLE;
			S_RND: begin
				if (iter_q == '0 || count_q == '0) begin
					state_d = S_PUSH;
				end else begin
					state_d = S_MOD;
				end
			end
			S_MOD:   if (rem_done) state_d = S_REMIT;
			S_REMIT: if (can_emit) state_d = S_SH_RD;
			S_SH_RD: begin
				if (int'(j_q) + 1 < int'(count_q)) begin
					state_d = S_SH_WR;
				end else begin
					state_d = S_RND;
				end
			end
			S_SH_WR: state_d = S_SH_RD;
			default: state_d = S_IDLE;
		endcase
	end

	// Per-state outputs: results, memory accesses and next register values.
	always_comb begin
		emit      = 1'b0;
		e_status  = ST_ACCEPTED;
		e_id      = id_q;
		e_last    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = phys(head_q, count_q);
		mem_wdata = id_q;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		rem_start = 1'b0;
		head_d    = head_q;
		count_d   = count_q;
		budget_d  = budget_q;
		lfsr_d    = lfsr_q;
		iter_d    = iter_q;
		j_d       = j_q;
		case (state_q)
			S_DISPATCH: begin
				case (cmd_q)
					CMD_PUSH: begin
						if (budget_q == '0 && policy_q != POL_BLOCK) begin
							emit     = can_emit;
							e_status = ST_DROPPED;
							e_last   = 1'b1;
						end else if (full) begin
							if (policy_q == POL_DROP_HEAD) begin
								mem_re = 1'b1;
							end else if (policy_q == POL_DROP_RAND) begin
								iter_d = ITER_W'((budget_q + CAP_W'(3)) >> 2);
							end else begin
								emit     = can_emit;
								e_status = (policy_q == POL_BLOCK) ? ST_REJECTED : ST_DROPPED;
								e_last   = 1'b1;
							end
						end
					end
					CMD_POP: begin
						if (count_q == '0) begin
							emit     = can_emit;
							e_status = ST_EMPTY;
							e_id     = '0;
							e_last   = 1'b1;
						end else begin
							mem_re = 1'b1;
						end
					end
					CMD_DONE: begin
						if (can_emit) begin
							emit     = 1'b1;
							e_status = ST_BUDGET;
							e_id     = '0;
							e_last   = 1'b1;
							if (budget_q < eff_cap) begin
								budget_d = budget_q + CAP_W'(1);
							end
						end
					end
					default: ;
				endcase
			end
			S_POP: begin
				if (can_emit) begin
					emit     = 1'b1;
					e_status = ST_POPPED;
					e_id     = mem_rdata;
					e_last   = 1'b1;
					head_d   = phys(head_q, CW'(1));
					count_d  = count_q - CW'(1);
					if (budget_q != '0) begin
						budget_d = budget_q - CAP_W'(1);
					end
				end
			end
			S_HEAD: begin
				if (can_emit) begin
					emit     = 1'b1;
					e_status = ST_EVICTED;
					e_id     = mem_rdata;
					head_d   = phys(head_q, CW'(1));
					count_d  = count_q - CW'(1);
				end
			end
			S_PUSH: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_last = 1'b1;
					if (int'(count_q) < QUEUE_DEPTH) begin
						mem_we   = 1'b1;
						count_d  = count_q + CW'(1);
						e_status = ST_ACCEPTED;
					end else begin
						e_status = ST_REJECTED;
					end
				end
			end
			S_RND: begin
				if (iter_q != '0 && count_q != '0) begin
					lfsr_d    = lfsr_next(lfsr_q);
					rem_start = 1'b1;
				end
			end
			S_MOD: begin
				if (rem_done) begin
					j_d       = rem_val;
					mem_re    = 1'b1;
					mem_raddr = phys(head_q, rem_val);
				end
			end
			S_REMIT: begin
				if (can_emit) begin
					emit     = 1'b1;
					e_status = ST_EVICTED;
					e_id     = mem_rdata;
				end
			end
			S_SH_RD: begin
				// Move the entry above the gap down by one, or close the pick.
				if (int'(j_q) + 1 < int'(count_q)) begin
					mem_re    = 1'b1;
					mem_raddr = phys(head_q, j_q + CW'(1));
				end else begin
					count_d = count_q - CW'(1);
					iter_d  = iter_q - ITER_W'(1);
				end
			end
			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_waddr = phys(head_q, j_q);
				mem_wdata = mem_rdata;
				j_d       = j_q + CW'(1);
			end
			default: ;
		endcase
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			policy_q <= POL_BLOCK;
			cap_q    <= CAP_W'(CAP_LIMIT);
			head_q   <= '0;
			count_q  <= '0;
			budget_q <= CAP_W'(CAP_MAX);
			lfsr_q   <= LFSR_ONE;
			iter_q   <= '0;
			j_q      <= '0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			iter_q   <= iter_d;
			j_q      <= j_d;
			// A configuration write takes the place of the sequencer's update.
			if (cfg_write && cfg_index == CFG_POLICY) begin
				policy_q <= policy_t'(cfg_data[POLICY_W-1:0]);
			end
			if (cfg_write && cfg_index == CFG_CAPACITY) begin
				cap_q <= cfg_data[CAP_W-1:0];
				if (cfg_data[CAP_W-1:0] > CAP_W'(CAP_MAX)) begin
					budget_q <= CAP_W'(CAP_MAX);
				end else begin
					budget_q <= cfg_data[CAP_W-1:0];
				end
			end else begin
				budget_q <= budget_d;
			end
			if (cfg_write && cfg_index == CFG_SEED) begin
				lfsr_q <= (cfg_data == '0) ? LFSR_ONE : cfg_data;
			end else begin
				lfsr_q <= lfsr_d;
			end
		end
	end

	// Command capture on an input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q <= cmd_t'(command);
			id_q  <= request_id;
		end
	end

	// Output register: loaded by a result, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= e_status;
			out_id_q     <= e_id;
			out_last_q   <= e_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign item_id     = out_id_q;
	assign last_result = out_last_q;

	// The queue never holds more entries than the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= QUEUE_DEPTH)
		else $error("entry count exceeds queue depth");

	// The budget never exceeds the capacity limit CAP_MAX.
	a_budget_bound: assert property (@(posedge clk) disable iff (!arst_n)
		budget_q <= CAP_W'(CAP_MAX))
		else $error("slot budget exceeds capacity limit");

	// The final result of a command returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_last) |=> state_q == S_IDLE)
		else $error("sequencer busy after final result");

	// The LFSR never locks up at zero.
	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("LFSR reached zero");

endmodule

@@ sv/brq_mem.sv @@
// Entry store of the request queue: one write port, one read port, registered read data.
// Depends on brq_pkg for the identifier width.
module brq_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [brq_pkg::ID_W-1:0] wdata,
	input  logic                   re,
	input  logic [AW-1:0]          raddr,
	output logic [brq_pkg::ID_W-1:0] rdata
);
	import brq_pkg::*;

	logic [ID_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/brq_rem.sv @@
// Bit-serial remainder unit: 16-bit dividend modulo a small count, one bit per cycle.
// Depends on brq_pkg for the LFSR width.
module brq_rem #(
	parameter int CW = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [brq_pkg::LFSR_W-1:0] dividend,
	input  logic [CW-1:0]            divisor,
	output logic                     done,
	output logic [CW-1:0]            rem
);
	import brq_pkg::*;

	logic [LFSR_W-1:0] div_q;
	logic [CW-1:0]     rem_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [CW:0]       trial;

	// Shift in the next dividend bit and subtract when the divisor fits.
	assign trial = {rem_q, div_q[LFSR_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(LFSR_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= div_q << 1;
			if (trial >= {1'b0, divisor}) begin
				rem_q <= CW'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[CW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ dv/bounded_request_queue_drop_policy_top_tb.sv @@
// Testbench for the bounded request queue with overflow drop policy.
// Depends on brq_pkg and bounded_request_queue_drop_policy_top; a queue-based
// predictor computes the expected results of every command transfer.
`timescale 1ns / 1ps

module bounded_request_queue_drop_policy_top_tb;
	import brq_pkg::*;

	typedef struct packed {
		status_t                 st;
		logic [ID_W-1:0]         id;
		logic                    last;
	} result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [CMD_W-1:0]      command;
	logic [ID_W-1:0]       request_id;
	logic                  out_valid;
	logic                  out_stall;
	logic [STATUS_W-1:0]   status;
	logic [ID_W-1:0]       item_id;
	logic                  last_result;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor state.
	policy_t          pol;
	int unsigned      cap_reg;
	logic [LFSR_W-1:0] lfsr;
	logic [ID_W-1:0]  fifo_ids[$];
	int unsigned      budget;
	result_t          pending_results[$];

	int  mismatches;
	int  sent;
	int  received;
	int  send_idle_pct;
	int  stall_pct;
	bit  hold_off;

	bounded_request_queue_drop_policy_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .request_id(request_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .item_id(item_id), .last_result(last_result),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Generous fixed limit on the whole run.
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int unsigned eff_cap();
		int unsigned c;
		c = cap_reg;
		if (c > CAP_LIMIT) c = CAP_LIMIT;
		if (c > QUEUE_DEPTH) c = QUEUE_DEPTH;
		return c;
	endfunction

	function automatic void add_result(status_t s, logic [ID_W-1:0] v);
		result_t r;
		r.st = s;
		r.id = v;
		r.last = 1'b0;
		pending_results.push_back(r);
	endfunction

	// Works out the results of one command and updates the predictor state.
	function automatic void predict_command(logic [CMD_W-1:0] c, logic [ID_W-1:0] v);
		int unsigned iters;
		int unsigned pick;
		int          n0;
		result_t     r;
		logic        lsb;
		n0 = pending_results.size();
		if (c == CMD_PUSH) begin
			if (budget == 0 && pol != POL_BLOCK) begin
				add_result(ST_DROPPED, v);
			end else if (fifo_ids.size() >= budget) begin
				if (pol == POL_BLOCK) begin
					add_result(ST_REJECTED, v);
				end else if (pol == POL_DROP_TAIL) begin
					add_result(ST_DROPPED, v);
				end else begin
					if (pol == POL_DROP_HEAD) begin
						add_result(ST_EVICTED, fifo_ids.pop_front());
					end else begin
						iters = (budget + 3) / 4;
						for (int i = 0; i < iters && fifo_ids.size() > 0; i++) begin
							lsb = lfsr[0];
							lfsr = lfsr >> 1;
							if (lsb) lfsr = lfsr ^ 16'hB400;
							pick = lfsr % fifo_ids.size();
							add_result(ST_EVICTED, fifo_ids[pick]);
							fifo_ids.delete(pick);
						end
					end
					if (fifo_ids.size() < QUEUE_DEPTH) begin
						fifo_ids.push_back(v);
						add_result(ST_ACCEPTED, v);
					end else begin
						add_result(ST_REJECTED, v);
					end
				end
			end else if (fifo_ids.size() < QUEUE_DEPTH) begin
				fifo_ids.push_back(v);
				add_result(ST_ACCEPTED, v);
			end else begin
				add_result(ST_REJECTED, v);
			end
		end else if (c == CMD_POP) begin
			if (fifo_ids.size() == 0) begin
				add_result(ST_EMPTY, '0);
			end else begin
				add_result(ST_POPPED, fifo_ids.pop_front());
				if (budget > 0) budget--;
			end
		end else if (c == CMD_DONE) begin
			if (budget < eff_cap()) budget++;
			add_result(ST_BUDGET, '0);
		end
		if (pending_results.size() > n0) begin
			r = pending_results[$];
			r.last = 1'b1;
			pending_results[pending_results.size() - 1] = r;
		end
	endfunction

	task automatic report_mismatch(string what, logic [ID_W-1:0] got, logic [ID_W-1:0] exp);
		mismatches++;
		$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, exp);
	endtask

	// Checks each result transfer against the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			received++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", ID_W'(status), '0);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) report_mismatch("status", ID_W'(status), ID_W'(e.st));
				if (item_id !== e.id) report_mismatch("item_id", item_id, e.id);
				if (last_result !== e.last) begin
					report_mismatch("last_result", ID_W'(last_result), ID_W'(e.last));
				end
			end
		end
	end

	// Receiver stall, changed at the falling edge.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) out_stall <= 1'b1;
			else out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Sends one command; the valid stays up across back-to-back transfers
	// and is dropped once the sender goes quiet.
	task automatic send_command(logic [CMD_W-1:0] c, logic [ID_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		request_id <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_command(c, v);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		// Room for a command that causes no result to finish.
		repeat (40) @(negedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == CFG_POLICY) pol = policy_t'(val[1:0]);
		else if (idx == CFG_CAPACITY) begin
			cap_reg = val[4:0];
			budget = eff_cap();
		end else if (idx == CFG_SEED) lfsr = (val == 0) ? LFSR_ONE : val;
	endtask

	function automatic logic [CMD_W-1:0] pick_command();
		int r;
		r = $urandom_range(99);
		if (r < 50) return CMD_PUSH;
		if (r < 78) return CMD_POP;
		if (r < 96) return CMD_DONE;
		return CMD_NOP;
	endfunction

	// Directed: field extremes, every command and policy, zero budget, empty pop.
	task automatic test_directed();
		send_command(CMD_POP, 32'h0);
		send_command(CMD_PUSH, 32'h0);
		send_command(CMD_PUSH, 32'hFFFF_FFFF);
		send_command(CMD_DONE, 32'h1234_5678);
		send_command(CMD_NOP, 32'hA5A5_A5A5);
		send_command(CMD_POP, 32'hFFFF_FFFF);
		send_command(CMD_POP, 32'h0);
		send_command(CMD_POP, 32'h0);
		write_register(CFG_CAPACITY, 16'd2);
		for (int p = 0; p < 4; p++) begin
			write_register(CFG_POLICY, CFG_DATA_W'(p));
			for (int i = 0; i < 4; i++) send_command(CMD_PUSH, 32'h100 * p + i);
		end
		// A capacity write of zero, below the current count, then pushes at zero budget.
		write_register(CFG_CAPACITY, 16'd0);
		send_command(CMD_PUSH, 32'h5555_AAAA);
		write_register(CFG_POLICY, CFG_DATA_W'(POL_BLOCK));
		send_command(CMD_PUSH, 32'hAAAA_5555);
		send_command(CMD_DONE, 32'h0);
	endtask

	// Random commands under one setting and one idling mix.
	task automatic test_random(int count, int unsigned cap, policy_t p, int idle, int stall);
		write_register(CFG_POLICY, CFG_DATA_W'(p));
		write_register(CFG_CAPACITY, CFG_DATA_W'(cap));
		write_register(CFG_SEED, CFG_DATA_W'($urandom_range(65535)));
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) send_command(pick_command(), $urandom);
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	// The receiver holds off while pushes keep coming, so the input stalls.
	task automatic test_backpressure();
		write_register(CFG_CAPACITY, 16'd31);
		write_register(CFG_POLICY, CFG_DATA_W'(POL_DROP_RAND));
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 20; i++) send_command(CMD_PUSH, $urandom);
		join
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_NOP;
		request_id = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_POLICY;
		cfg_data = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		sent = 0;
		received = 0;
		pol = POL_BLOCK;
		cap_reg = 16;
		budget = 16;
		lfsr = LFSR_ONE;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(70, 16, POL_DROP_RAND, 0, 0);
		test_random(70, 16, POL_DROP_RAND, 62, 0);
		test_random(60, 5, POL_DROP_HEAD, 0, 62);
		test_random(60, 9, POL_DROP_TAIL, 25, 25);
		test_random(60, 0, POL_DROP_RAND, 0, 0);
		test_random(40, 31, POL_BLOCK, 25, 25);
		test_backpressure();
		write_register(CFG_SEED, 16'hFFFF);
		write_register(CFG_SEED, 16'h0000);
		test_random(20, 12, POL_DROP_RAND, 0, 0);
		wait_drained();
		$display("Covered %0d commands and %0d results over all policies,", sent, received);
		$display("capacities 0 to 31, seed extremes, idling, stalls and a long hold-off.");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/brq_pkg.sv
sv/brq_mem.sv
sv/brq_rem.sv
sv/bounded_request_queue_drop_policy_top.sv
dv/bounded_request_queue_drop_policy_top_tb.sv
